// ----- hdl/gcb_pkg.sv -----
`timescale 1ns / 1ps
// gcb_pkg: shared constants, result type and fixed-point helpers for the
// great-circle bearing/distance unit. No dependencies.
package gcb_pkg;

  localparam int CORDIC_STAGES_DEF = 24;

  // Field widths
  localparam int LAT_W  = 21;
  localparam int LON_W  = 22;
  localparam int RAD_W  = 24;
  localparam int BRG_W  = 16;
  localparam int DIST_W = 31;

  // Internal datapath widths
  localparam int HW     = 25;  // angle in 1/20000 degree
  localparam int MAG_W  = 21;
  localparam int RW     = 33;  // rotation CORDIC vector/angle
  localparam int VW     = 35;  // vectoring CORDIC vector/angle
  localparam int Q_W    = 32;  // Q30 trig values
  localparam int SQ_W   = 62;  // square-root working width
  localparam int A_W    = 31;  // haversine term, Q30 in [0,1]
  localparam int DIV_W  = 47;  // bearing scaling remainder
  localparam int DQ_W   = 15;  // bearing scaling quotient
  localparam int R100_W = 31;

  localparam int SC_LANES   = 5;
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = 15;

  localparam logic [31:0] PI_Q30   = 32'd3373259426;
  localparam logic [31:0] PI_HALF  = 32'd1686629713;
  localparam logic [31:0] KINV_Q30 = 32'd652032874;
  localparam int UNITS_90  = 1800000;
  localparam int UNITS_180 = 3600000;
  localparam int UNITS_360 = 7200000;

  // Degree-unit to Q30 scaling: PI_Q30 = 937 * UNITS_180 + PI_FRAC.
  localparam int PI_WHOLE = 937;
  localparam int PI_FRAC  = 59426;
  // floor(x / 28125) = (x * RECIP_28125) >> RECIP_SH for x < 2^30
  localparam logic [30:0] RECIP_28125 = 31'd1250999897;
  localparam int RECIP_SH = 45;

  localparam logic [R100_W-1:0] R100_RESET = 31'd637100000;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam int FULL_TURN_CDEG = 36000;

  typedef struct packed {
    logic [BRG_W-1:0]  bearing;
    logic [DIST_W-1:0] distance;
  } res_t;

  // Arctangent table entry in Q30; evaluated at elaboration only.
  function automatic logic [63:0] atan_entry(input int unsigned i);
    logic [63:0] sum;
    logic [63:0] t;
    int unsigned k;
    sum = '0;
    k = 0;
    if (i == 0) begin
      return (64'(PI_Q30) + 64'd2) >> 2;
    end
    while (i * (2 * k + 1) < 61) begin
      t = ((64'd1 << 60) >> (i * (2 * k + 1))) / 64'(2 * k + 1);
      if (k[0]) sum = sum - t;
      else sum = sum + t;
      k = k + 1;
    end
    return (sum + (64'd1 << 29)) >> 30;
  endfunction

  // Q30 product, rounded half up
  function automatic logic signed [Q_W-1:0] mulq(input logic signed [Q_W-1:0] a,
                                                  input logic signed [Q_W-1:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return p[61:30];
  endfunction

endpackage

// ----- hdl/gcb_ifs.sv -----
`timescale 1ns / 1ps
// Channel interfaces for the great-circle bearing/distance unit:
// position pairs in, results out, radius write. Depends on gcb_pkg.
interface gcb_pos_if;
  logic valid;
  logic ready;
  logic signed [gcb_pkg::LAT_W-1:0] node_lat;
  logic signed [gcb_pkg::LON_W-1:0] node_lon;
  logic signed [gcb_pkg::LAT_W-1:0] target_lat;
  logic signed [gcb_pkg::LON_W-1:0] target_lon;
  modport source(output valid, node_lat, node_lon, target_lat, target_lon, input ready);
  modport sink(input valid, node_lat, node_lon, target_lat, target_lon, output ready);
endinterface

interface gcb_res_if;
  logic valid;
  logic ready;
  logic [gcb_pkg::BRG_W-1:0]  bearing_centideg;
  logic [gcb_pkg::DIST_W-1:0] distance_cm;
  modport source(output valid, bearing_centideg, distance_cm, input ready);
  modport sink(input valid, bearing_centideg, distance_cm, output ready);
endinterface

interface gcb_cfg_if;
  logic valid;
  logic ready;
  logic [gcb_pkg::RAD_W-1:0] earth_radius_m;
  modport source(output valid, earth_radius_m, input ready);
  modport sink(input valid, earth_radius_m, output ready);
endinterface

// ----- hdl/gcb_rot_cell.sv -----
`timescale 1ns / 1ps
// gcb_rot_cell: one rotation-mode CORDIC step, registered.
// Depends on gcb_pkg (arctangent table).
module gcb_rot_cell #(
  parameter int I = 0,
  parameter int W = gcb_pkg::RW
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] x_in,
  input  logic signed [W-1:0] y_in,
  input  logic signed [W-1:0] z_in,
  input  logic                flag_in,
  output logic signed [W-1:0] x,
  output logic signed [W-1:0] y,
  output logic signed [W-1:0] z,
  output logic                flag
);
  import gcb_pkg::*;

  localparam logic signed [W-1:0] ATAN = W'(atan_entry(I));

  logic signed [W-1:0] dx, dy;
  assign dx = y_in >>> I;
  assign dy = x_in >>> I;

  always_ff @(posedge clk) begin
    if (en) begin
      if (z_in >= 0) begin
        x <= x_in - dx;
        y <= y_in + dy;
        z <= z_in - ATAN;
      end else begin
        x <= x_in + dx;
        y <= y_in - dy;
        z <= z_in + ATAN;
      end
      flag <= flag_in;
    end
  end
endmodule

// ----- hdl/gcb_vec_cell.sv -----
`timescale 1ns / 1ps
// gcb_vec_cell: one vectoring-mode CORDIC step (atan2), registered.
// Depends on gcb_pkg (arctangent table).
module gcb_vec_cell #(
  parameter int I = 0,
  parameter int W = gcb_pkg::VW
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] x_in,
  input  logic signed [W-1:0] y_in,
  input  logic signed [W-1:0] z_in,
  input  logic                flag_in,
  output logic signed [W-1:0] x,
  output logic signed [W-1:0] y,
  output logic signed [W-1:0] z,
  output logic                flag
);
  import gcb_pkg::*;

  localparam logic signed [W-1:0] ATAN = W'(atan_entry(I));

  logic signed [W-1:0] dx, dy;
  assign dx = y_in >>> I;
  assign dy = x_in >>> I;

  always_ff @(posedge clk) begin
    if (en) begin
      if (y_in >= 0) begin
        x <= x_in + dx;
        y <= y_in - dy;
        z <= z_in + ATAN;
      end else begin
        x <= x_in - dx;
        y <= y_in + dy;
        z <= z_in - ATAN;
      end
      flag <= flag_in;
    end
  end
endmodule

// ----- hdl/gcb_sqrt_cell.sv -----
`timescale 1ns / 1ps
// gcb_sqrt_cell: one digit step of a floor integer square root, registered.
// Depends on gcb_pkg (step count).
module gcb_sqrt_cell #(
  parameter int J = 0,
  parameter int W = gcb_pkg::SQ_W
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] v_in,
  input  logic [W-1:0] res_in,
  output logic [W-1:0] v,
  output logic [W-1:0] res
);
  import gcb_pkg::*;

  localparam int POS = 2 * (SQRT_STEPS - 1 - J);
  localparam logic [W-1:0] BIT = W'(1) << POS;

  logic [W-1:0] trial;
  assign trial = res_in + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (v_in >= trial) begin
        v   <= v_in - trial;
        res <= (res_in >> 1) + BIT;
      end else begin
        v   <= v_in;
        res <= res_in >> 1;
      end
    end
  end
endmodule

// ----- hdl/gcb_div_cell.sv -----
`timescale 1ns / 1ps
// gcb_div_cell: one restoring-division step by pi (Q30), registered.
// Depends on gcb_pkg (PI_Q30).
module gcb_div_cell #(
  parameter int K  = 0,
  parameter int W  = gcb_pkg::DIV_W,
  parameter int QW = gcb_pkg::DQ_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [W-1:0]  rem_in,
  input  logic [QW-1:0] q_in,
  input  logic          flag_in,
  output logic [W-1:0]  rem,
  output logic [QW-1:0] q,
  output logic          flag
);
  import gcb_pkg::*;

  localparam logic [W-1:0] DSH = W'(PI_Q30) << K;

  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_in >= DSH) begin
        rem <= rem_in - DSH;
        q   <= q_in | (QW'(1) << K);
      end else begin
        rem <= rem_in;
        q   <= q_in;
      end
      flag <= flag_in;
    end
  end
endmodule

// ----- hdl/great_circle_bearing_distance_unit.sv -----
`timescale 1ns / 1ps
// great_circle_bearing_distance_unit: initial bearing and haversine distance
// per position pair. Depends on gcb_pkg, gcb_ifs and the four cell modules.
//
//  channel | dir | transfer carries
//  --------+-----+--------------------------------------------------------
//  pos     | in  | node_lat, node_lon, target_lat, target_lon (1e-4 deg)
//  res     | out | bearing_centideg (0.01 deg), distance_cm (saturating)
//  cfg     | in  | earth_radius_m (metres), always ready
//
// One pair per cycle sustained while res keeps taking results; all lanes
// are rows of registered cells (rotation CORDIC, square root, vectoring
// CORDIC, restoring divider) that move together and hold while the skid
// register is full.
// Reset (rst, sync) clears valid bits (pipeline, output, skid) and sets radius (6371 km).
// A stall on res fills a skid register; pos.ready drops only when it's full.
module great_circle_bearing_distance_unit #(
  parameter int CORDIC_STAGES = gcb_pkg::CORDIC_STAGES_DEF
) (
  input  logic clk,
  input  logic rst,
  gcb_cfg_if.sink   cfg,
  gcb_pos_if.sink   pos,
  gcb_res_if.source res
);
  import gcb_pkg::*;

  localparam int N    = CORDIC_STAGES;
  localparam int LAT  = 2 * N + 49;
  localparam int BDLY = 17;  // bearing path is this much shorter

  localparam logic signed [HW-1:0] U90  = HW'(UNITS_90);
  localparam logic signed [HW-1:0] U180 = HW'(UNITS_180);
  localparam logic signed [HW-1:0] U360 = HW'(UNITS_360);
  localparam logic signed [VW-1:0] PI_V = VW'(PI_Q30);

  // ---------------- handshake / control ----------------
  logic           en;
  logic [LAT-1:0] vld;
  logic           ov, sv, take, incoming;
  res_t           ob, sb, pipe_res;

  assign en        = !sv;
  assign pos.ready = en;
  assign take      = ov && res.ready;
  assign incoming  = vld[LAT-1] && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], pos.valid};
    end
  end

  // output register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else begin
      if (incoming) begin
        if (!ov || take) begin
          ov <= 1'b1;
          ob <= pipe_res;
        end else begin
          sv <= 1'b1;
          sb <= pipe_res;
        end
      end else if (take) begin
        if (sv) begin
          ob <= sb;
          sv <= 1'b0;
        end else begin
          ov <= 1'b0;
        end
      end
    end
  end

  assign res.valid            = ov;
  assign res.bearing_centideg = ob.bearing;
  assign res.distance_cm      = ob.distance;

  // ---------------- radius register (stored as metres * 100) ----------------
  logic [R100_W-1:0] r100;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      r100 <= R100_RESET;
    end else if (cfg.valid) begin
      r100 <= R100_W'(cfg.earth_radius_m) * R100_W'(100);
    end
  end

  // ---------------- P0: input capture ----------------
  logic signed [LAT_W-1:0] p0_nlat, p0_tlat;
  logic signed [LON_W-1:0] p0_nlon, p0_tlon;

  always_ff @(posedge clk) begin
    if (en) begin
      p0_nlat <= pos.node_lat;
      p0_nlon <= pos.node_lon;
      p0_tlat <= pos.target_lat;
      p0_tlon <= pos.target_lon;
    end
  end

  // ---------------- P1: angles in 1/20000 degree ----------------
  // lane 0: node lat, 1: target lat, 2: dlon (full), 3: dlat/2, 4: dlon/2
  logic signed [HW-1:0] h1 [SC_LANES];
  logic signed [HW-1:0] dlat_c, dlon_c;

  assign dlat_c = HW'(p0_tlat) - HW'(p0_nlat);
  assign dlon_c = HW'(p0_tlon) - HW'(p0_nlon);

  always_ff @(posedge clk) begin
    if (en) begin
      h1[0] <= HW'(p0_nlat) <<< 1;
      h1[1] <= HW'(p0_tlat) <<< 1;
      h1[2] <= dlon_c <<< 1;
      h1[3] <= dlat_c;
      h1[4] <= dlon_c;
    end
  end

  // ---------------- sine/cosine lanes ----------------
  logic signed [HW-1:0]    r2 [SC_LANES];
  logic signed [HW-1:0]    r3 [SC_LANES];
  logic signed [HW-1:0]    r4 [SC_LANES];
  logic                    n4 [SC_LANES];
  logic [MAG_W-1:0]        mag5 [SC_LANES];
  logic                    n5 [SC_LANES];
  logic                    s5 [SC_LANES];
  logic [30:0]             ph6 [SC_LANES];
  logic [36:0]             pl6 [SC_LANES];
  logic                    n6 [SC_LANES];
  logic                    s6 [SC_LANES];
  logic [60:0]             pq7 [SC_LANES];
  logic [30:0]             ph7 [SC_LANES];
  logic                    n7 [SC_LANES];
  logic                    s7 [SC_LANES];
  logic signed [RW-1:0]    rx [SC_LANES][N+1];
  logic signed [RW-1:0]    ry [SC_LANES][N+1];
  logic signed [RW-1:0]    rz [SC_LANES][N+1];
  logic                    rn [SC_LANES][N+1];
  logic signed [Q_W-1:0]   cosv [SC_LANES];
  logic signed [Q_W-1:0]   sinv [SC_LANES];

  for (genvar l = 0; l < SC_LANES; l++) begin : g_sc
    logic signed [HW-1:0] r4_abs;
    logic [30:0]          zmag;
    logic signed [RW-1:0] xneg, yneg;

    assign r4_abs = (r4[l] < 0) ? -r4[l] : r4[l];
    assign zmag   = ph7[l] + 31'(pq7[l][60:RECIP_SH]);
    assign xneg   = -rx[l][N];
    assign yneg   = -ry[l][N];

    always_ff @(posedge clk) begin
      if (en) begin
        // P2: truncating remainder by a full turn
        if (h1[l] >= U360) r2[l] <= h1[l] - U360;
        else if (h1[l] <= -U360) r2[l] <= h1[l] + U360;
        else r2[l] <= h1[l];
        // P3: into [-180, 180)
        if (r2[l] >= U180) r3[l] <= r2[l] - U360;
        else if (r2[l] < -U180) r3[l] <= r2[l] + U360;
        else r3[l] <= r2[l];
        // P4: fold past +-90, outputs negated later
        if (r3[l] > U90) begin
          r4[l] <= r3[l] - U180;
          n4[l] <= 1'b1;
        end else if (r3[l] < -U90) begin
          r4[l] <= r3[l] + U180;
          n4[l] <= 1'b1;
        end else begin
          r4[l] <= r3[l];
          n4[l] <= 1'b0;
        end
        // P5: magnitude
        mag5[l] <= r4_abs[MAG_W-1:0];
        s5[l]   <= r4[l] < 0;
        n5[l]   <= n4[l];
        // P6: mag*pi split into whole and fractional multiples of 180 deg
        ph6[l] <= 31'(mag5[l]) * 31'(PI_WHOLE);
        pl6[l] <= 37'(mag5[l]) * 37'(PI_FRAC) + 37'(UNITS_90);
        n6[l]  <= n5[l];
        s6[l]  <= s5[l];
        // P7: divide fractional part by 180 deg via reciprocal
        pq7[l] <= 61'(pl6[l][36:7]) * 61'(RECIP_28125);
        ph7[l] <= ph6[l];
        n7[l]  <= n6[l];
        s7[l]  <= s6[l];
        // P8: CORDIC start vector
        rx[l][0] <= RW'(KINV_Q30);
        ry[l][0] <= '0;
        rz[l][0] <= s7[l] ? -$signed({2'b00, zmag}) : $signed({2'b00, zmag});
        rn[l][0] <= n7[l];
        // output sign
        cosv[l] <= rn[l][N] ? xneg[Q_W-1:0] : rx[l][N][Q_W-1:0];
        sinv[l] <= rn[l][N] ? yneg[Q_W-1:0] : ry[l][N][Q_W-1:0];
      end
    end

    for (genvar j = 0; j < N; j++) begin : g_rot
      gcb_rot_cell #(.I(j), .W(RW)) u_rot (
        .clk(clk), .en(en),
        .x_in(rx[l][j]), .y_in(ry[l][j]), .z_in(rz[l][j]), .flag_in(rn[l][j]),
        .x(rx[l][j+1]), .y(ry[l][j+1]), .z(rz[l][j+1]), .flag(rn[l][j+1])
      );
    end
  end

  // ---------------- M1..M4: products ----------------
  logic signed [Q_W-1:0] m1_ctsd, m1_cnst, m1_snct, m1_cnct, m1_h2sq, m1_h1sq, m1_cd;
  logic signed [Q_W-1:0] m2_bx, m2_cnst, m2_t, m2_prod, m2_h1sq;
  logic signed [Q_W:0]   m3_bx, m3_by;
  logic signed [Q_W:0]   a_raw;
  logic [A_W-1:0]        m3_a, m4_a, m4_b;

  assign a_raw = (Q_W+1)'(m2_h1sq) + (Q_W+1)'(m2_prod);

  always_ff @(posedge clk) begin
    if (en) begin
      m1_ctsd <= mulq(cosv[1], sinv[2]);
      m1_cnst <= mulq(cosv[0], sinv[1]);
      m1_snct <= mulq(sinv[0], cosv[1]);
      m1_cnct <= mulq(cosv[0], cosv[1]);
      m1_h2sq <= mulq(sinv[4], sinv[4]);
      m1_h1sq <= mulq(sinv[3], sinv[3]);
      m1_cd   <= cosv[2];

      m2_bx   <= m1_ctsd;
      m2_cnst <= m1_cnst;
      m2_t    <= mulq(m1_snct, m1_cd);
      m2_prod <= mulq(m1_cnct, m1_h2sq);
      m2_h1sq <= m1_h1sq;

      m3_bx <= (Q_W+1)'(m2_bx);
      m3_by <= (Q_W+1)'(m2_cnst) - (Q_W+1)'(m2_t);
      if (a_raw < 0) m3_a <= '0;
      else if (a_raw > (Q_W+1)'(1 << 30)) m3_a <= A_W'(1 << 30);
      else m3_a <= a_raw[A_W-1:0];

      m4_a <= m3_a;
      m4_b <= A_W'(1 << 30) - m3_a;
    end
  end

  // ---------------- square roots of a and 1-a (Q60 in, Q30 out) ----------------
  logic [SQ_W-1:0] sq_v   [2][SQRT_STEPS+1];
  logic [SQ_W-1:0] sq_res [2][SQRT_STEPS+1];

  assign sq_v[0][0]   = {1'b0, m4_a, 30'd0};
  assign sq_v[1][0]   = {1'b0, m4_b, 30'd0};
  assign sq_res[0][0] = '0;
  assign sq_res[1][0] = '0;

  for (genvar l = 0; l < 2; l++) begin : g_sq
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
      gcb_sqrt_cell #(.J(j), .W(SQ_W)) u_sqrt (
        .clk(clk), .en(en),
        .v_in(sq_v[l][j]), .res_in(sq_res[l][j]),
        .v(sq_v[l][j+1]), .res(sq_res[l][j+1])
      );
    end
  end

  // ---------------- atan2 lanes: 0 bearing, 1 central angle ----------------
  logic signed [VW-1:0] vin_x [2];
  logic signed [VW-1:0] vin_y [2];
  logic signed [VW-1:0] vx [2][N+1];
  logic signed [VW-1:0] vy [2][N+1];
  logic signed [VW-1:0] vz [2][N+1];
  logic                 vzero [2][N+1];

  assign vin_y[0] = VW'(m3_bx);
  assign vin_x[0] = VW'(m3_by);
  assign vin_y[1] = $signed(VW'(sq_res[0][SQRT_STEPS][A_W-1:0]));
  assign vin_x[1] = $signed(VW'(sq_res[1][SQRT_STEPS][A_W-1:0]));

  for (genvar l = 0; l < 2; l++) begin : g_at
    always_ff @(posedge clk) begin
      if (en) begin
        vzero[l][0] <= (vin_x[l] == 0) && (vin_y[l] == 0);
        if (vin_x[l] < 0) begin
          vz[l][0] <= (vin_y[l] >= 0) ? PI_V : -PI_V;
          vx[l][0] <= -vin_x[l];
          vy[l][0] <= -vin_y[l];
        end else begin
          vz[l][0] <= '0;
          vx[l][0] <= vin_x[l];
          vy[l][0] <= vin_y[l];
        end
      end
    end

    for (genvar j = 0; j < N; j++) begin : g_vec
      gcb_vec_cell #(.I(j), .W(VW)) u_vec (
        .clk(clk), .en(en),
        .x_in(vx[l][j]), .y_in(vy[l][j]), .z_in(vz[l][j]), .flag_in(vzero[l][j]),
        .x(vx[l][j+1]), .y(vy[l][j+1]), .z(vz[l][j+1]), .flag(vzero[l][j+1])
      );
    end
  end

  // ---------------- bearing: |b|*18000/pi, rounded, wrapped ----------------
  logic signed [VW-1:0] bz, bz_abs;
  logic [31:0]          b1_m;
  logic                 b1_neg;
  logic [DIV_W-1:0]     dv_rem [DIV_STEPS+1];
  logic [DQ_W-1:0]      dv_q   [DIV_STEPS+1];
  logic                 dv_neg [DIV_STEPS+1];
  logic [16:0]          cd_t;
  logic [BRG_W-1:0]     bear_f;
  logic [BRG_W-1:0]     bdl [BDLY];

  assign bz     = vzero[0][N] ? '0 : vz[0][N];
  assign bz_abs = (bz < 0) ? -bz : bz;
  assign cd_t   = dv_neg[DIV_STEPS] ? 17'(FULL_TURN_CDEG) - 17'(dv_q[DIV_STEPS])
                                    : 17'(dv_q[DIV_STEPS]);
  assign dv_q[0] = '0;

  always_ff @(posedge clk) begin
    if (en) begin
      b1_m      <= bz_abs[31:0];
      b1_neg    <= bz < 0;
      dv_rem[0] <= DIV_W'(b1_m) * DIV_W'(18000) + DIV_W'(PI_HALF);
      dv_neg[0] <= b1_neg;
      bear_f    <= (cd_t >= 17'(FULL_TURN_CDEG)) ? BRG_W'(cd_t - 17'(FULL_TURN_CDEG))
                                                 : BRG_W'(cd_t);
      bdl[0]    <= bear_f;
      for (int k = 1; k < BDLY; k++) bdl[k] <= bdl[k-1];
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    gcb_div_cell #(.K(DIV_STEPS - 1 - j), .W(DIV_W), .QW(DQ_W)) u_div (
      .clk(clk), .en(en),
      .rem_in(dv_rem[j]), .q_in(dv_q[j]), .flag_in(dv_neg[j]),
      .rem(dv_rem[j+1]), .q(dv_q[j+1]), .flag(dv_neg[j+1])
    );
  end

  // ---------------- distance: c*R*100, rounded, saturated ----------------
  logic signed [VW-1:0] dz;
  logic [31:0]          c_ang;
  logic [62:0]          dprod;
  logic [63:0]          dsum;
  logic [DIST_W-1:0]    dist_sat;

  assign dz   = vzero[1][N] ? '0 : vz[1][N];
  assign dsum = 64'(dprod) + (64'd1 << 29);

  always_ff @(posedge clk) begin
    if (en) begin
      c_ang    <= (dz < 0) ? '0 : 32'(dz <<< 1);
      dprod    <= 63'(c_ang) * 63'(r100);
      dist_sat <= (dsum[63:30] > 34'(DIST_MAX)) ? DIST_MAX : dsum[30+DIST_W-1:30];
    end
  end

  assign pipe_res.bearing  = bdl[BDLY-1];
  assign pipe_res.distance = dist_sat;

  // ---------------- assertions ----------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid holds a result while output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(sv) |-> $past(ov && !res.ready))
    else $error("skid filled without an output stall");

  a_bearing_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.bearing_centideg < BRG_W'(FULL_TURN_CDEG)))
    else $error("bearing outside one turn");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for great_circle_bearing_distance_unit.
// Depends on gcb_pkg, gcb_ifs and the unit itself.
module tb_top;
  import gcb_pkg::*;

  localparam int STAGES = 24;
  localparam longint PI_L  = 64'sd3373259426;
  localparam longint KINV_L = 64'sd652032874;
  localparam longint U90  = 64'sd1800000;
  localparam longint U180 = 64'sd3600000;
  localparam longint U360 = 64'sd7200000;
  localparam longint Q30_ONE = 64'sd1073741824;
  localparam int SETTLE = 2 * STAGES + 80;  // beyond pipeline latency

  typedef struct {
    logic signed [LAT_W-1:0] nlat;
    logic signed [LON_W-1:0] nlon;
    logic signed [LAT_W-1:0] tlat;
    logic signed [LON_W-1:0] tlon;
  } pos_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gcb_cfg_if cfg_ch();
  gcb_pos_if pos_ch();
  gcb_res_if res_ch();

  great_circle_bearing_distance_unit #(.CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst(rst), .cfg(cfg_ch), .pos(pos_ch), .res(res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bench-side copy of the unit's radius register and atan table
  logic [RAD_W-1:0] radius_m;
  longint atan_q[STAGES];

  pos_pair_t pending_pairs[$];
  res_t      expected_res[$];
  int        n_errors = 0;
  bit        hold_tx = 1'b0;   // sender paused by the sequencer
  bit        quiet = 1'b0;     // no idling in the closing part
  int        tx_gap = 0;
  int        rx_stall = 0;

  function automatic void build_atan();
    longint unsigned sum, t;
    int unsigned k;
    atan_q[0] = (PI_L + 2) / 4;
    for (int i = 1; i < STAGES; i++) begin
      sum = 0;
      k = 0;
      while (i * (2 * k + 1) < 61) begin
        t = ((64'd1 << 60) >> (i * (2 * k + 1))) / (2 * k + 1);
        if (k[0]) sum = sum - t;
        else sum = sum + t;
        k++;
      end
      atan_q[i] = longint'((sum + (64'd1 << 29)) >> 30);
    end
  endfunction

  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  // sine/cosine of an angle in 1/20000 degree, rotation CORDIC
  function automatic void sin_cos(input longint h, output longint c, output longint s);
    longint r, mag, x, y, z, dx, dy;
    bit neg;
    neg = 1'b0;
    r = h % U360;
    if (r >= U180) r -= U360;
    if (r < -U180) r += U360;
    if (r > U90) begin
      r -= U180;
      neg = 1'b1;
    end else if (r < -U90) begin
      r += U180;
      neg = 1'b1;
    end
    mag = (r < 0) ? -r : r;
    z = (mag * PI_L + U90) / U180;
    if (r < 0) z = -z;
    x = KINV_L;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q[i];
      end else begin
        x += dx; y -= dy; z += atan_q[i];
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  // atan2 by vectoring CORDIC; (0,0) gives 0
  function automatic longint arc_tan2(input longint yi, input longint xi);
    longint x, y, z, dx, dy;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_L : -PI_L;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_q[i];
      end else begin
        x -= dx; y += dy; z -= atan_q[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else root >>= 1;
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic res_t bearing_and_distance(input pos_pair_t p);
    longint dlat, dlon, cn, sn, ct, st, cd, sd, ch1, sh1, ch2, sh2;
    longint bx, by, b, m, cdeg, hav, c;
    longint unsigned ra, rb, dist_cm;
    res_t r;
    dlat = longint'(p.tlat) - longint'(p.nlat);
    dlon = longint'(p.tlon) - longint'(p.nlon);
    sin_cos(2 * longint'(p.nlat), cn, sn);
    sin_cos(2 * longint'(p.tlat), ct, st);
    sin_cos(2 * dlon, cd, sd);
    // bearing
    bx = q30_mul(ct, sd);
    by = q30_mul(cn, st) - q30_mul(q30_mul(sn, ct), cd);
    b = arc_tan2(bx, by);
    m = (b < 0) ? -b : b;
    cdeg = (m * 18000 + PI_L / 2) / PI_L;
    if (b < 0) cdeg = 36000 - cdeg;
    if (cdeg >= 36000) cdeg -= 36000;
    // haversine: half angles, so plain units act as 1/20000 degree
    sin_cos(dlat, ch1, sh1);
    sin_cos(dlon, ch2, sh2);
    hav = q30_mul(sh1, sh1) + q30_mul(q30_mul(cn, ct), q30_mul(sh2, sh2));
    if (hav < 0) hav = 0;
    if (hav > Q30_ONE) hav = Q30_ONE;
    ra = floor_sqrt(longint'(unsigned'(hav)) << 30);
    rb = floor_sqrt((Q30_ONE - hav) << 30);
    c = 2 * arc_tan2(longint'(ra), longint'(rb));
    if (c < 0) c = 0;
    dist_cm = (longint'(unsigned'(c)) * (longint'(radius_m) * 100) + (64'd1 << 29)) >> 30;
    if (dist_cm > 64'd2147483647) dist_cm = 64'd2147483647;
    r.bearing = cdeg[BRG_W-1:0];
    r.distance = dist_cm[DIST_W-1:0];
    return r;
  endfunction

  // Sender: predicts on each transfer, then either idles or presents the next pair.
  pos_pair_t nxt;
  pos_pair_t acc;
  always @(posedge clk) begin
    if (rst) begin
      pos_ch.valid <= 1'b0;
    end else begin
      if (pos_ch.valid && pos_ch.ready) begin
        acc.nlat = pos_ch.node_lat;
        acc.nlon = pos_ch.node_lon;
        acc.tlat = pos_ch.target_lat;
        acc.tlon = pos_ch.target_lon;
        expected_res = {expected_res, bearing_and_distance(acc)};
      end
      if (!pos_ch.valid || pos_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          pos_ch.valid <= 1'b0;
        end else if (pending_pairs.size() > 0 && !hold_tx) begin
          if (!quiet && $urandom_range(0, 11) == 0) begin
            tx_gap = $urandom_range(0, 4);  // start a burst of idle cycles
            pos_ch.valid <= 1'b0;
          end else begin
            nxt = pending_pairs.pop_front();
            pos_ch.node_lat   <= nxt.nlat;
            pos_ch.node_lon   <= nxt.nlon;
            pos_ch.target_lat <= nxt.tlat;
            pos_ch.target_lon <= nxt.tlon;
            pos_ch.valid <= 1'b1;
          end
        end else begin
          pos_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transfer against the oldest prediction.
  res_t want;
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result bearing %0d distance %0d", $time,
                   res_ch.bearing_centideg, res_ch.distance_cm);
          n_errors++;
        end else begin
          want = expected_res.pop_front();
          if (res_ch.bearing_centideg !== want.bearing) begin
            $display("%0t: bearing_centideg expected %0d actual %0d", $time,
                     want.bearing, res_ch.bearing_centideg);
            n_errors++;
          end
          if (res_ch.distance_cm !== want.distance) begin
            $display("%0t: distance_cm expected %0d actual %0d", $time,
                     want.distance, res_ch.distance_cm);
            n_errors++;
          end
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        res_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        rx_stall = $urandom_range(0, 4);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic add_pair(input int nl, input int no, input int tl, input int to);
    pos_pair_t p;
    p.nlat = nl[LAT_W-1:0];
    p.nlon = no[LON_W-1:0];
    p.tlat = tl[LAT_W-1:0];
    p.tlon = to[LON_W-1:0];
    pending_pairs = {pending_pairs, p};
  endtask

  function automatic int rnd_span(input int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // mostly on-globe pairs, some nearby, some raw bit patterns
  task automatic add_random(input int n);
    int nl, no;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: add_pair($urandom, $urandom, $urandom, $urandom);
        2, 3: begin
          nl = rnd_span(900000);
          no = rnd_span(1800000);
          add_pair(nl, no, nl + rnd_span(200), no + rnd_span(200));
        end
        default: add_pair(rnd_span(900000), rnd_span(1800000),
                          rnd_span(900000), rnd_span(1800000));
      endcase
    end
  endtask

  task automatic wait_drained();
    wait (pending_pairs.size() == 0 && !pos_ch.valid && expected_res.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // radius write only while the pipeline is empty
  task automatic set_radius(input logic [RAD_W-1:0] v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.earth_radius_m <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    radius_m = v;
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    build_atan();
    radius_m = 24'd6371000;
    cfg_ch.valid = 1'b0;
    cfg_ch.earth_radius_m = '0;
    pos_ch.valid = 1'b0;
    pos_ch.node_lat = '0;
    pos_ch.node_lon = '0;
    pos_ch.target_lat = '0;
    pos_ch.target_lon = '0;
    res_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: coincident, poles, antipodes, date line, field extremes
    add_pair(0, 0, 0, 0);
    add_pair(123456, -654321, 123456, -654321);
    add_pair(0, 0, 0, 1800000);
    add_pair(0, 0, 0, -1800000);
    add_pair(900000, 0, -900000, 0);
    add_pair(-900000, 0, 900000, 0);
    add_pair(900000, 1800000, -900000, -1800000);
    add_pair(0, 0, 900000, 0);
    add_pair(0, 0, -900000, 0);
    add_pair(0, 0, 0, 900000);
    add_pair(0, 0, 0, -900000);
    add_pair(0, 1799999, 0, -1799999);
    add_pair(0, 0, 1, 0);
    add_pair(0, 0, 0, 1);
    add_pair(450000, 100000, 450000, 100001);
    add_pair(-1048576, -2097152, 1048575, 2097151);
    add_pair(1048575, 2097151, -1048576, -2097152);
    add_pair(-1048576, 0, -1048576, 0);
    add_pair(0, 2097151, 0, -2097152);
    add_pair(899999, 0, 899999, 1800000);
    add_random(250);
    // sender holds off mid-phase until every result is back
    wait (pending_pairs.size() < 100);
    hold_tx = 1'b1;
    wait (expected_res.size() == 0);
    hold_tx = 1'b0;
    wait_drained();

    set_radius(24'd1);
    add_pair(0, 0, 0, 1800000);
    add_random(250);
    wait_drained();

    set_radius(24'hFFFFFF);  // long distances saturate here
    add_pair(0, 0, 0, 1800000);
    add_pair(900000, 0, -900000, 0);
    add_random(250);
    wait_drained();

    set_radius(24'd0);
    add_random(150);
    wait_drained();

    set_radius(24'($urandom_range(1, 16777215)));
    add_random(300);
    wait_drained();

    set_radius(24'd6371000);
    quiet = 1'b1;
    add_random(330);
    wait_drained();

    if (n_errors == 0 && expected_res.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule
